// ----- hdl/bse_pkg.sv -----
// shared constants and types for the streaming bubble sort block
package bse_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int Q_DEPTH  = 4;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    // one classified element on its way from the front to the back
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic                    store;
        logic                    ovf;
    } q_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- hdl/bse_front.sv -----
// input side: counts the elements of a list, drops those past capacity, tags the last one
module bse_front
    import bse_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic signed [VAL_W-1:0] s_tdata,
    input  logic                    s_tlast,
    input  q_stat_t                 q_stat,
    output logic                    push,
    output q_item_t                 push_item
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             drop_reg, drop_next;
    logic             accept, room;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign room     = cnt_reg < CNT_W'(CAPACITY);

    // a dropped element only travels on when it closes the list
    assign push            = accept && (room || s_tlast);
    assign push_item.value = s_tdata;
    assign push_item.last  = s_tlast;
    assign push_item.store = room;
    assign push_item.ovf   = drop_reg || !room;

    always_comb begin
        cnt_next  = cnt_reg;
        drop_next = drop_reg;
        if (accept) begin
            if (s_tlast) begin
                cnt_next  = '0;
                drop_next = 1'b0;
            end else if (room) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end else begin
                drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
        end
    end

endmodule

// ----- hdl/bse_fifo.sv -----
// short queue of classified elements between the front and the back
module bse_fifo
    import bse_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  q_item_t push_item,
    input  logic    pop,
    output q_item_t pop_item,
    output q_stat_t q_stat
);

    q_item_t           mem [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg, fill_next;

    assign q_stat.full  = fill_reg == QCNT_W'(Q_DEPTH);
    assign q_stat.empty = fill_reg == '0;
    assign pop_item     = mem[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- hdl/bse_back.sv -----
// back end: chain of compare cells kept in ascending order, then drained smallest first
module bse_back
    import bse_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  q_stat_t                 q_stat,
    input  q_item_t                 pop_item,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic signed [VAL_W-1:0] m_tdata,
    output logic                    m_tlast,
    output logic                    m_tuser
);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic signed [VAL_W-1:0] cell_reg  [CAPACITY];
    logic                    valid_reg [CAPACITY];
    logic signed [VAL_W-1:0] cell_next [CAPACITY];
    logic                    keep      [CAPACITY];
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ovf_reg;
    logic                    out_free;

    assign pop      = (state_reg == ST_LOAD) && !q_stat.empty;
    assign out_free = !m_tvalid || m_tready;

    // each cell keeps its value if it is occupied and not above the new one,
    // takes the new value at the boundary, otherwise takes its left neighbor
    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            assign keep[k] = valid_reg[k] && !(cell_reg[k] > pop_item.value);
            if (k == 0) begin : g_first
                assign cell_next[k] = keep[k] ? cell_reg[k] : pop_item.value;
            end else begin : g_rest
                assign cell_next[k] = keep[k]   ? cell_reg[k] :
                                      keep[k-1] ? pop_item.value : cell_reg[k-1];
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            m_tvalid  <= 1'b0;
            for (int i = 0; i < CAPACITY; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (m_tready) begin
                        m_tvalid <= 1'b0;
                    end
                    if (pop) begin
                        if (pop_item.store) begin
                            for (int i = 0; i < CAPACITY; i++) begin
                                cell_reg[i] <= cell_next[i];
                            end
                            valid_reg[0] <= 1'b1;
                            for (int i = 1; i < CAPACITY; i++) begin
                                valid_reg[i] <= valid_reg[i] || valid_reg[i-1];
                            end
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                        if (pop_item.last) begin
                            ovf_reg   <= pop_item.ovf;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    // not free means valid is held against a low ready
                    if (out_free) begin
                        m_tvalid <= 1'b1;
                        m_tdata  <= cell_reg[0];
                        m_tlast  <= cnt_reg == CNT_W'(1);
                        m_tuser  <= ovf_reg;
                        for (int i = 0; i < CAPACITY - 1; i++) begin
                            cell_reg[i]  <= cell_reg[i+1];
                            valid_reg[i] <= valid_reg[i+1];
                        end
                        valid_reg[CAPACITY-1] <= 1'b0;
                        cnt_reg <= cnt_reg - CNT_W'(1);
                        if (cnt_reg == CNT_W'(1)) begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    if (m_tready) begin
                        m_tvalid <= 1'b0;
                    end
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

// ----- hdl/bubble_sort_early_exit.sv -----
// top level of the streaming ascending sort: front, queue and sorting back end
//
//  channel | dir | fields
//  s_      | in  | tdata[31:0] value (signed), tlast last
//  m_      | out | tdata[31:0] sorted_value (signed), tlast last_res, tuser overflow
//
// one element per cycle while a list loads and the queue is not empty: each
// request is inserted into the ordered cell chain in the cycle it leaves the
// queue. after the last element the stored elements drain smallest first, held
// while m_tready is low; the input keeps taking requests until the queue (4) fills.
// aresetn is synchronous and clears counts, queue pointers and cell valid bits.
module bubble_sort_early_exit
    import bse_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic signed [VAL_W-1:0] s_tdata,   // [31:0] value
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic signed [VAL_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                    m_tlast,
    output logic                    m_tuser    // [0] overflow
);

    q_stat_t q_stat;
    q_item_t push_item, pop_item;
    logic    push, pop;

    bse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    bse_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    bse_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_item (pop_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_stat.full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable({m_tvalid, m_tdata, m_tlast, m_tuser}))
        else $error("output changed while stalled");

endmodule
